FILE: hw/rtl/atlsc_pkg.sv
`default_nettype none

package atlsc_pkg;

  // light colour codes
  typedef enum logic [1:0] {
    COL_GREEN  = 2'd0,
    COL_ORANGE = 2'd1,
    COL_RED    = 2'd2
  } colour_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MIN_HOLD = 2'd0,
    REG_MAX_HOLD = 2'd1,
    REG_VISIBLE  = 2'd2
  } cfg_reg_e;

  localparam int unsigned HoldW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgDataW = 16;

  // reset values of the configuration registers
  localparam logic [HoldW-1:0] MinHoldRst = 16'd50;
  localparam logic [HoldW-1:0] MaxHoldRst = 16'd300;
  localparam logic             VisibleRst = 1'b1;

  // orange is done once its elapsed time reaches this, in tenths of a second
  localparam logic [TimeW-1:0] OrangeCap = 32'd50;

endpackage

`default_nettype wire

FILE: hw/rtl/actuated_two_light_signal_controller.sv
`default_nettype none

// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+---------------------------------------
// in       | input     | in_valid_i/in_stall_o | light_i, now_i, demand_first_i/second_i
// out      | output    | out_valid_o/out_stall_i | colour_first_o, colour_second_o
// cfg      | input     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// one beat per cycle in each direction while the output does not stall; a taken input
// beat passes the input register, then the light update into the result register
// the light state updates in the same edge as the result register, so the next
// beat sees it without a bubble
// reset brings first green, second red, all times zero and the register defaults
// an output stall holds the result and the input register; in_stall_o rises only
// when both are full

module actuated_two_light_signal_controller (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             light_i,
  input  wire logic [atlsc_pkg::TimeW-1:0]      now_i,
  input  wire logic                             demand_first_i,
  input  wire logic                             demand_second_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [1:0]                            colour_first_o,
  output logic [1:0]                            colour_second_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [1:0]                       cfg_index_i,
  input  wire logic [atlsc_pkg::CfgDataW-1:0]   cfg_data_i
);
  import atlsc_pkg::*;

  // configuration registers
  logic [HoldW-1:0] min_hold_q, max_hold_q;
  logic             visible_q;

  // input register
  logic             in_vld_q;
  logic             light_q;
  logic [TimeW-1:0] now_q;
  logic [1:0]       dem_q;

  // light state
  colour_e          colour_q [2];
  colour_e          colour_d [2];
  logic [TimeW-1:0] last_q [2];
  logic [TimeW-1:0] last_d [2];
  logic [TimeW-1:0] seen_q [2];
  logic [TimeW-1:0] seen_d [2];

  // result register
  logic             out_vld_q;
  colour_e          out_col_q [2];

  logic             adv;
  logic             in_acc;
  logic [TimeW:0]   elapsed [2];
  logic [TimeW+3:0] elapsed_x10 [2];
  logic [1:0]       orange_done;
  logic [TimeW:0]   e_l;
  logic             hold_ok, forced;
  logic             req;
  logic             req_x;
  logic             req_y;
  colour_e          col_l, col_y;
  logic             dem_l, dem_o;

  // handshake: the update stage moves when the result register is free
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_hold_q <= MinHoldRst;
      max_hold_q <= MaxHoldRst;
      visible_q  <= VisibleRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MIN_HOLD: min_hold_q <= cfg_data_i[HoldW-1:0];
        REG_MAX_HOLD: max_hold_q <= cfg_data_i[HoldW-1:0];
        REG_VISIBLE:  visible_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      light_q <= light_i;
      now_q   <= now_i;
      dem_q   <= {demand_second_i, demand_first_i};
    end
  end

  // per-light seen time and elapsed time, signed one bit wider, and the orange-done flag
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      seen_d[i]      = (light_q == 1'(i)) ? now_q : seen_q[i];
      elapsed[i]     = {1'b0, seen_d[i]} - {1'b0, last_q[i]};
      elapsed_x10[i] = {1'b0, elapsed[i][TimeW-1:0], 3'b000} +
                       {3'b000, elapsed[i][TimeW-1:0], 1'b0};
      orange_done[i] = !elapsed[i][TimeW] &&
                       (!visible_q ||
                        (elapsed[i][TimeW-1:0] >= OrangeCap) ||
                        (elapsed_x10[i] >= {{(TimeW+4-HoldW){1'b0}}, max_hold_q}));
    end
  end

  // rules for the updated light
  always_comb begin
    col_l   = colour_q[light_q];
    dem_l   = dem_q[light_q];
    dem_o   = dem_q[~light_q];
    e_l     = elapsed[light_q];
    hold_ok = !e_l[TimeW] && (e_l[TimeW-1:0] >= {{(TimeW-HoldW){1'b0}}, min_hold_q});
    forced  = !e_l[TimeW] && (e_l[TimeW-1:0] >  {{(TimeW-HoldW){1'b0}}, max_hold_q});
    req     = 1'b0;
    req_x   = light_q;
    if (hold_ok) begin
      if (forced) begin
        req   = 1'b1;
        req_x = (col_l == COL_RED) ? light_q : ~light_q;
      end else if (col_l == COL_RED && dem_l && !dem_o) begin
        req   = 1'b1;
        req_x = light_q;
      end
    end
    req_y = ~req_x;
    col_y = colour_q[req_y];
  end

  // handover: green turns orange, orange gives way once its time is up
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      colour_d[i] = colour_q[i];
      last_d[i]   = last_q[i];
    end
    if (req) begin
      if (col_y == COL_GREEN) begin
        colour_d[req_y] = COL_ORANGE;
        last_d[req_y]   = seen_d[req_y];
      end else if (col_y == COL_ORANGE && orange_done[req_y]) begin
        colour_d[req_x] = COL_GREEN;
        last_d[req_x]   = seen_d[req_x];
        colour_d[req_y] = COL_RED;
        last_d[req_y]   = seen_d[req_y];
      end
    end
  end

  // light state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_q[0] <= COL_GREEN;
      colour_q[1] <= COL_RED;
      last_q[0]   <= '0;
      last_q[1]   <= '0;
      seen_q[0]   <= '0;
      seen_q[1]   <= '0;
    end else if (adv) begin
      for (int i = 0; i < 2; i++) begin
        colour_q[i] <= colour_d[i];
        last_q[i]   <= last_d[i];
        seen_q[i]   <= seen_d[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_col_q[0] <= colour_d[0];
      out_col_q[1] <= colour_d[1];
    end
  end

  assign out_valid_o     = out_vld_q;
  assign colour_first_o  = out_col_q[0];
  assign colour_second_o = out_col_q[1];

  // at least one light is always red
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (colour_q[0] == COL_RED) || (colour_q[1] == COL_RED))
    else $error("both lights away from red");

  // a colour change stamps the light with its own seen time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (colour_q[0] != $past(colour_q[0])) |-> (last_q[0] == seen_q[0]))
    else $error("first light changed without a time stamp");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (colour_q[1] != $past(colour_q[1])) |-> (last_q[1] == seen_q[1]))
    else $error("second light changed without a time stamp");

  // light state only moves with an update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(colour_q[0]) && $stable(colour_q[1])))
    else $error("colour changed without an update");

endmodule

`default_nettype wire
